### rtl/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
`timescale 1ns / 1ps

package ptb_pkg;

	// Default parameter values
	localparam int NUM_TIMERS_DEF  = 4;
	localparam int COUNT_WIDTH_DEF = 16;

	// Fixed field widths set by the register packing
	localparam int MAX_CH   = 4;
	localparam int PERIOD_W = 16;
	localparam int FLAG_W   = 8;
	localparam int CFG_W    = 64;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIODS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASKS   = 2'd2;

	// Request codes
	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_RESTART = 2'd1,
		REQ_CLEAR   = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	// Token handed from cell to cell while a tick walks the chain
	typedef struct packed {
		logic              go;
		logic [FLAG_W-1:0] flags;
		logic [MAX_CH-1:0] expired;
	} tok_t;

endpackage

### rtl/periodic_timer_bank_with_flags.sv
// Top level of the periodic timer bank: config registers, control and result register.
//
//  channel | valid     | flow control | word
//  --------+-----------+--------------+--------------------------------
//  in      | in_valid  | in_stall     | req_type, handle, flag_mask
//  out     | out_valid | out_stall    | flags, expired
//  cfg     | cfg_valid | cfg_ready    | cfg_index, cfg_data
//
// A tick walks the cell chain one cell per cycle, from cell 0 to cell CH_COUNT-1,
// before the next word can be taken (CH_COUNT = min(NUM_TIMERS, 4)). Restart, clear
// and no-op words skip the chain. One word is in flight at a time.
// Reset zeroes all counts, the flag byte and the config registers.
// A stalled result holds in the output register; a finished word waits for it.
`timescale 1ns / 1ps

module periodic_timer_bank_with_flags #(
	parameter int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF,
	parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input words
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [1:0]                    handle,
	input  logic [ptb_pkg::FLAG_W-1:0]    flag_mask,
	// results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ptb_pkg::FLAG_W-1:0]    flags,
	output logic [ptb_pkg::MAX_CH-1:0]    expired,
	// config writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ptb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptb_pkg::CFG_W-1:0]     cfg_data
);
	import ptb_pkg::*;

	localparam int CH_COUNT = (NUM_TIMERS < MAX_CH) ? NUM_TIMERS : MAX_CH;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HAND = 3'b100
	} state_t;

	state_t                    state_q;
	logic [MAX_CH-1:0]         en_q;
	logic [MAX_CH*PERIOD_W-1:0] periods_q;
	logic [MAX_CH*FLAG_W-1:0]  masks_q;
	logic [FLAG_W-1:0]         flag_q;
	logic [MAX_CH-1:0]         exp_res_q;
	logic                      out_valid_q;
	logic [FLAG_W-1:0]         out_flags_q;
	logic [MAX_CH-1:0]         out_exp_q;

	req_t                      req;
	logic                      in_acc;
	logic                      cfg_wr;
	logic [MAX_CH-1:0]         en_rise;
	logic                      slot_free;
	tok_t                      tok_chain [0:CH_COUNT];
	logic [CH_COUNT:1]         go_vec;

	assign req       = req_t'(req_type);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign slot_free = !out_valid_q || !out_stall;

	// Enable bits turning on zero their channel
	assign en_rise = (cfg_wr && (cfg_index == REG_ENABLE)) ?
	                 (cfg_data[MAX_CH-1:0] & ~en_q) : '0;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= '0;
			periods_q <= '0;
			masks_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_ENABLE:  en_q      <= cfg_data[MAX_CH-1:0];
				REG_PERIODS: periods_q <= cfg_data[MAX_CH*PERIOD_W-1:0];
				REG_MASKS:   masks_q   <= cfg_data[MAX_CH*FLAG_W-1:0];
				default:     ;
			endcase
		end
	end

	// Tick token enters the chain at cell 0 with the current flag byte
	assign tok_chain[0].go      = in_acc && (req == REQ_TICK);
	assign tok_chain[0].flags   = flag_q;
	assign tok_chain[0].expired = '0;

	// Row of timer cells
	for (genvar i = 0; i < CH_COUNT; i++) begin : g_cell
		localparam logic [1:0] HND = 2'(i);
		logic clr;

		assign clr = en_rise[i] || (in_acc && (req == REQ_RESTART) && (handle == HND));

		ptb_cell #(
			.COUNT_WIDTH (COUNT_WIDTH),
			.CELL_IDX    (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.enable  (en_q[i]),
			.period  (periods_q[i*PERIOD_W +: PERIOD_W]),
			.mask    (masks_q[i*FLAG_W +: FLAG_W]),
			.clr     (clr),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1])
		);

		assign go_vec[i+1] = tok_chain[i+1].go;
	end

	// Control: accept, wait for the token, then hand off to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			flag_q    <= '0;
			exp_res_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (req)
							REQ_TICK: begin
								state_q <= ST_RUN;
							end
							REQ_CLEAR: begin
								flag_q    <= flag_q & ~flag_mask;
								exp_res_q <= '0;
								state_q   <= ST_HAND;
							end
							default: begin
								exp_res_q <= '0;
								state_q   <= ST_HAND;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (tok_chain[CH_COUNT].go) begin
						flag_q    <= tok_chain[CH_COUNT].flags;
						exp_res_q <= tok_chain[CH_COUNT].expired;
						state_q   <= ST_HAND;
					end
				end
				ST_HAND: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_HAND) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_HAND) && slot_free) begin
			out_flags_q <= flag_q;
			out_exp_q   <= exp_res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign flags     = out_flags_q;
	assign expired   = out_exp_q;

	// Token reaches the end of the chain after passing the register of every cell
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (req == REQ_TICK)) |-> ##CH_COUNT tok_chain[CH_COUNT].go)
		else $error("tick token did not reach chain end on time");

	// Only one token ever walks the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(go_vec))
		else $error("more than one token in the cell chain");

	// Non-tick words report no expiry
	a_nontick_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (req != REQ_TICK)) |=> (exp_res_q == '0))
		else $error("non-tick word carries expired bits");

	// Channels beyond the chain never expire
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_exp_q >> CH_COUNT) == '0))
		else $error("expired bit set for a missing channel");

endmodule

### rtl/ptb_cell.sv
// One timer cell: a down-counter that services the tick token and passes it on.
`timescale 1ns / 1ps

module ptb_cell #(
	parameter int COUNT_WIDTH = 16,
	parameter int CELL_IDX    = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         enable,
	input  logic [ptb_pkg::PERIOD_W-1:0] period,
	input  logic [ptb_pkg::FLAG_W-1:0]   mask,
	input  logic                         clr,
	input  ptb_pkg::tok_t                tok_in,
	output ptb_pkg::tok_t                tok_out
);
	import ptb_pkg::*;

	localparam logic [MAX_CH-1:0] OWN_BIT = MAX_CH'(1) << CELL_IDX;

	logic [COUNT_WIDTH-1:0]          count_q;
	logic [COUNT_WIDTH+PERIOD_W-1:0] per_ext;
	logic [COUNT_WIDTH-1:0]          reload;
	logic                            fire;
	tok_t                            tok_q;

	// Period zero-extended, then cut to the counter width
	assign per_ext = {{COUNT_WIDTH{1'b0}}, period};
	assign reload  = per_ext[COUNT_WIDTH-1:0];
	assign fire    = tok_in.go && enable && (count_q == '0);

	// Down-counter: clear wins, else count on the token while enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (tok_in.go && enable) begin
			if (count_q == '0) begin
				count_q <= reload;
			end else begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Hand the token to the neighbor, adding this cell's mask and expired bit on expiry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.go      <= tok_in.go;
			tok_q.flags   <= tok_in.flags | (fire ? mask : '0);
			tok_q.expired <= tok_in.expired | (fire ? OWN_BIT : '0);
		end
	end

	assign tok_out = tok_q;

endmodule

### tb/sv/periodic_timer_bank_with_flags_tb.sv
// Self-checking testbench for the periodic timer bank with shared flag byte.
`timescale 1ns / 1ps

module periodic_timer_bank_with_flags_tb;
	import ptb_pkg::*;

	// Index with no register behind it; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS   = 245;

	typedef struct {
		req_t              kind;
		logic [1:0]        chan;
		logic [FLAG_W-1:0] clr;
	} bank_req_t;

	typedef struct {
		logic [FLAG_W-1:0] flags;
		logic [MAX_CH-1:0] expired;
	} bank_status_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [1:0]           req_type  = '0;
	logic [1:0]           handle    = '0;
	logic [FLAG_W-1:0]    flag_mask = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [FLAG_W-1:0]    flags;
	logic [MAX_CH-1:0]    expired;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shadow copy of the bank
	logic [MAX_CH-1:0]   en_shadow;
	logic [63:0]         period_shadow;
	logic [31:0]         mask_shadow;
	logic [PERIOD_W-1:0] count_shadow [MAX_CH];
	logic [FLAG_W-1:0]   flag_shadow;

	bank_req_t    req_queue[$];
	bank_status_t expected_status[$];
	int unsigned  words_queued  = 0;
	int unsigned  results_taken = 0;
	int unsigned  errors        = 0;
	int unsigned  cycle_count   = 0;
	int unsigned  tx_gap        = 0;
	int unsigned  rx_hold       = 0;
	bit           no_idle       = 1'b0;

	periodic_timer_bank_with_flags uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.handle    (handle),
		.flag_mask (flag_mask),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flags     (flags),
		.expired   (expired),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (int ch = 0; ch < MAX_CH; ch++) count_shadow[ch] = '0;
		en_shadow     = '0;
		period_shadow = '0;
		mask_shadow   = '0;
		flag_shadow   = '0;
	end

	function automatic int unsigned draw_wait();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Advance the shadow bank by one word and record the status it should report
	task automatic step_bank(input logic [1:0] kind, input logic [1:0] chan,
			input logic [FLAG_W-1:0] clr);
		bank_status_t s;
		s.expired = '0;
		case (req_t'(kind))
			REQ_TICK: begin
				for (int ch = 0; ch < MAX_CH; ch++) begin
					if (en_shadow[ch]) begin
						if (count_shadow[ch] == '0) begin
							flag_shadow |= mask_shadow[ch*8 +: 8];
							count_shadow[ch] = period_shadow[ch*16 +: 16];
							s.expired[ch] = 1'b1;
						end else begin
							count_shadow[ch] = count_shadow[ch] - 1'b1;
						end
					end
				end
			end
			REQ_RESTART: count_shadow[chan] = '0;
			REQ_CLEAR:   flag_shadow &= ~clr;
			default: ;
		endcase
		s.flags = flag_shadow;
		expected_status.push_back(s);
	endtask

	// Shadow register file; an enable bit going high restarts that channel
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE: begin
					for (int ch = 0; ch < MAX_CH; ch++)
						if (cfg_data[ch] && !en_shadow[ch]) count_shadow[ch] = '0;
					en_shadow = cfg_data[MAX_CH-1:0];
				end
				REG_PERIODS: period_shadow = cfg_data;
				REG_MASKS:   mask_shadow = cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Request driver: holds a stalled word, then waits its drawn gap
	always @(posedge clk) begin : req_drv
		bank_req_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) step_bank(req_type, handle, flag_mask);
			if (!(in_valid && in_stall)) begin
				if (tx_gap != 0) begin
					tx_gap   <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					nxt = req_queue.pop_front();
					req_type  <= nxt.kind;
					handle    <= nxt.chan;
					flag_mask <= nxt.clr;
					in_valid  <= 1'b1;
					tx_gap    <= draw_wait();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk) begin : status_mon
		bank_status_t want;
		int unsigned hold;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_taken++;
				if (expected_status.size() == 0) begin
					report_mismatch($sformatf("unexpected word flags=%h expired=%h",
						flags, expired));
				end else begin
					want = expected_status.pop_front();
					if (flags !== want.flags)
						report_mismatch($sformatf("flags %h, want %h", flags, want.flags));
					if (expired !== want.expired)
						report_mismatch($sformatf("expired %h, want %h", expired,
							want.expired));
				end
				hold = draw_wait();
			end else if (rx_hold != 0) begin
				hold = rx_hold - 1;
			end else begin
				hold = 0;
			end
			rx_hold   <= hold;
			out_stall <= (hold != 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("periodic_timer_bank_with_flags verification failed");
			$finish;
		end
	end

	task automatic queue_req(input req_t kind, input logic [1:0] chan,
			input logic [FLAG_W-1:0] clr);
		bank_req_t r;
		r.kind = kind;
		r.chan = chan;
		r.clr  = clr;
		req_queue.push_back(r);
		words_queued++;
	endtask

	task automatic queue_random();
		int unsigned pick;
		req_t kind;
		pick = $urandom_range(0, 99);
		if (pick < 55) kind = REQ_TICK;
		else if (pick < 75) kind = REQ_RESTART;
		else if (pick < 90) kind = REQ_CLEAR;
		else kind = REQ_NONE;
		queue_req(kind, 2'($urandom_range(0, 3)), 8'($urandom));
	endtask

	// Wait until every word has answered and the bank has gone quiet
	task automatic settle();
		while (results_taken != words_queued) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly short periods so channels fire often, with the odd long one
	function automatic logic [15:0] rand_period();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7) return 16'($urandom_range(0, 6));
		if (r == 7) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	initial begin : stimulus
		logic [63:0] periods;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset: nothing enabled, flag byte zero
		queue_req(REQ_TICK, 2'd0, 8'h00);
		queue_req(REQ_NONE, 2'd3, 8'hFF);
		queue_req(REQ_CLEAR, 2'd1, 8'hFF);
		settle();

		// Periods 0, 1, max, 2 and distinct masks
		write_reg(REG_PERIODS, {16'd2, 16'hFFFF, 16'd1, 16'd0});
		write_reg(REG_MASKS, 64'({8'hC3, 8'h3C, 8'h80, 8'h01}));
		write_reg(REG_UNUSED, {CFG_W{1'b1}});
		write_reg(REG_ENABLE, 64'hF);
		queue_req(REQ_TICK, 2'd0, 8'h00);
		queue_req(REQ_TICK, 2'd1, 8'h00);
		queue_req(REQ_CLEAR, 2'd0, 8'hFF);
		queue_req(REQ_TICK, 2'd2, 8'hFF);
		queue_req(REQ_RESTART, 2'd2, 8'h00);
		queue_req(REQ_TICK, 2'd0, 8'h00);
		queue_req(REQ_CLEAR, 2'd3, 8'h00);
		queue_req(REQ_NONE, 2'd2, 8'hFF);
		queue_req(REQ_RESTART, 2'd3, 8'hFF);
		queue_req(REQ_TICK, 2'd0, 8'h00);
		settle();

		// Disabled channels hold; a restart still zeroes their count
		write_reg(REG_ENABLE, 64'h5);
		queue_req(REQ_TICK, 2'd0, 8'h00);
		queue_req(REQ_RESTART, 2'd1, 8'h00);
		queue_req(REQ_TICK, 2'd0, 8'h00);
		settle();

		// Re-enable: only channels 1 and 3 restart, 0 and 2 keep their count
		write_reg(REG_ENABLE, 64'hF);
		queue_req(REQ_TICK, 2'd0, 8'h00);
		queue_req(REQ_CLEAR, 2'd0, 8'h5A);
		settle();

		// Random phases under changing settings
		for (int phase = 0; phase < 8; phase++) begin
			no_idle = (phase % 3 == 2);
			case (phase)
				0: begin
					write_reg(REG_PERIODS, 64'h0);
					write_reg(REG_MASKS, 64'hFFFF_FFFF);
					write_reg(REG_ENABLE, 64'hF);
				end
				1: begin
					write_reg(REG_PERIODS, {CFG_W{1'b1}});
					write_reg(REG_MASKS, 64'($urandom));
					write_reg(REG_ENABLE, 64'h0);
					write_reg(REG_ENABLE, 64'hF);
				end
				2: begin
					write_reg(REG_MASKS, 64'h0);
					write_reg(REG_ENABLE, 64'h0);
				end
				default: begin
					periods = {rand_period(), rand_period(), rand_period(), rand_period()};
					write_reg(REG_PERIODS, periods);
					write_reg(REG_MASKS, 64'($urandom));
					if ($urandom_range(0, 3) == 0)
						write_reg(REG_UNUSED, {$urandom, $urandom});
					write_reg(REG_ENABLE, 64'($urandom_range(0, 15)));
				end
			endcase
			repeat (PHASE_WORDS) queue_random();
			settle();
		end

		if (errors == 0) begin
			$display("periodic_timer_bank_with_flags verification clean");
		end else begin
			$display("periodic_timer_bank_with_flags verification failed");
		end
		$finish;
	end

endmodule

### periodic_timer_bank_with_flags.f
rtl/ptb_pkg.sv
rtl/ptb_cell.sv
rtl/periodic_timer_bank_with_flags.sv
tb/sv/periodic_timer_bank_with_flags_tb.sv
